// File: rtl/cordic_rotate_vector_hyperbolic_defines.svh
// Assertion macros for the CORDIC rotate/vector/hyperbolic pipeline.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CORDIC_ROTATE_VECTOR_HYPERBOLIC_DEFINES_SVH
`define CORDIC_ROTATE_VECTOR_HYPERBOLIC_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CRVH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CRVH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crvh_pkg.sv
// Shared constants, codes and angle tables for the CORDIC pipeline.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package crvh_pkg;

    // Default configuration and datapath margins
    localparam int ITERATIONS_DEF = 16;
    localparam int DATA_WIDTH_DEF = 24;
    localparam int GUARD          = 4;
    localparam int HEADROOM       = 3;
    localparam int MAX_STEPS      = 20;

    // Circular gain inverse 0.6072529350 in Q30, split into high and low halves
    localparam longint          KINV_Q30   = 64'sd652032874;
    localparam int              KINV_SPLIT = 15;
    localparam logic signed [15:0] KINV_HI = 16'(KINV_Q30 >>> KINV_SPLIT);
    localparam logic signed [15:0] KINV_LO = 16'(KINV_Q30 & 64'sh7FFF);

    // Function codes
    typedef enum logic [1:0] {
        FUNC_ROT_COMP = 2'd0,
        FUNC_ROT_RAW  = 2'd1,
        FUNC_VECTOR   = 2'd2,
        FUNC_HYP      = 2'd3
    } func_t;

    // Gain compensation lane select
    typedef struct packed {
        logic scale_x;
        logic scale_y;
    } gain_sel_t;

    // atan(2^-i) in Q30
    localparam longint CIRC_Q30 [MAX_STEPS] = '{
        64'sd843314857, 64'sd497837830, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
        64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
        64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048
    };

    // atanh(2^-s) in Q30, indexed by s-1
    localparam longint HYP_Q30 [18] = '{
        64'sd589812982, 64'sd274247418, 64'sd134923406, 64'sd67196451, 64'sd33565361,
        64'sd16778582,  64'sd8388779,   64'sd4194325,   64'sd2097155,  64'sd1048576,
        64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,    64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096
    };

    // Hyperbolic shift sequence, steps 4 and 13 repeated
    localparam int HYP_SHIFT [MAX_STEPS] = '{
        1, 2, 3, 4, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 13, 14, 15, 16, 17, 18
    };

    // Q30 angle to datapath format (fraction bits dw-4 plus guard), round half up
    function automatic longint angle_const(input longint q30, input int dw);
        int s;
        s = 30 - (dw - 4) - GUARD;
        if (s > 0)
        begin
            return (q30 + (64'sd1 <<< (s - 1))) >>> s;
        end
        return q30 <<< (-s);
    endfunction

endpackage

`default_nettype wire

// File: rtl/crvh_gain.sv
// Two-stage gain compensation: multiply by the circular gain inverse, then sum and round.
// Depends on crvh_pkg; used before and after the micro-rotation stages.
`default_nettype none

module crvh_gain #(
    parameter int DATA_WIDTH = crvh_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  crvh_pkg::gain_sel_t         up_sel,
    input  logic [1:0]                  up_func,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_x,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_y,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_z,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [1:0]                  dn_func,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_x,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_y,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_z
);

`include "cordic_rotate_vector_hyperbolic_defines.svh"

    localparam int W = DATA_WIDTH + crvh_pkg::GUARD + crvh_pkg::HEADROOM;
    localparam int P = W + 16;
    localparam logic signed [P-1:0] ROUND_HALF = P'(1 << (crvh_pkg::KINV_SPLIT - 1));

    // hi + floor(lo/2^15) partial sum, rounded half up and scaled back
    function automatic logic signed [W-1:0] kinv_round(
        input logic signed [P-1:0] hi,
        input logic signed [P-1:0] lo
    );
        logic signed [P-1:0] sum;
        logic signed [P-1:0] shifted;
        sum     = hi + (lo >>> crvh_pkg::KINV_SPLIT) + ROUND_HALF;
        shifted = sum >>> crvh_pkg::KINV_SPLIT;
        return shifted[W-1:0];
    endfunction

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 s2_ready;
    crvh_pkg::gain_sel_t  sel1_reg;
    logic [1:0]           func1_reg;
    logic signed [W-1:0]  x1_reg;
    logic signed [W-1:0]  y1_reg;
    logic signed [W-1:0]  z1_reg;
    logic signed [P-1:0]  xhi1_reg;
    logic signed [P-1:0]  xlo1_reg;
    logic signed [P-1:0]  yhi1_reg;
    logic signed [P-1:0]  ylo1_reg;
    logic signed [P-1:0]  xhi1_next;
    logic signed [P-1:0]  xlo1_next;
    logic signed [P-1:0]  yhi1_next;
    logic signed [P-1:0]  ylo1_next;
    logic [1:0]           func2_reg;
    logic signed [W-1:0]  x2_reg;
    logic signed [W-1:0]  y2_reg;
    logic signed [W-1:0]  z2_reg;
    logic signed [W-1:0]  x2_next;
    logic signed [W-1:0]  y2_next;

    // Handshake: each stage moves when the one after it is empty or moving
    assign s2_ready = !v2_reg || dn_ready;
    assign up_ready = !v1_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                v1_reg <= up_valid;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage 1: partial products against both halves of the gain inverse
    assign xhi1_next = up_x * $signed(crvh_pkg::KINV_HI);
    assign xlo1_next = up_x * $signed(crvh_pkg::KINV_LO);
    assign yhi1_next = up_y * $signed(crvh_pkg::KINV_HI);
    assign ylo1_next = up_y * $signed(crvh_pkg::KINV_LO);

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            sel1_reg  <= up_sel;
            func1_reg <= up_func;
            x1_reg    <= up_x;
            y1_reg    <= up_y;
            z1_reg    <= up_z;
            xhi1_reg  <= xhi1_next;
            xlo1_reg  <= xlo1_next;
            yhi1_reg  <= yhi1_next;
            ylo1_reg  <= ylo1_next;
        end
    end

    // Stage 2: rounded scaled value or pass-through per lane
    assign x2_next = sel1_reg.scale_x ? kinv_round(xhi1_reg, xlo1_reg) : x1_reg;
    assign y2_next = sel1_reg.scale_y ? kinv_round(yhi1_reg, ylo1_reg) : y1_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            func2_reg <= func1_reg;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            z2_reg    <= z1_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_func  = func2_reg;
    assign dn_x     = x2_reg;
    assign dn_y     = y2_reg;
    assign dn_z     = z2_reg;

    // A beat held in stage 1 behind a stalled stage 2 is not dropped
    `CRVH_ASSERT_NEXT(a_gain_s1_hold, v1_reg && v2_reg && !dn_ready, v1_reg, "gain stage 1 lost a beat")
    // A stalled output beat keeps its value
    `CRVH_ASSERT_NEXT(a_gain_s2_hold, v2_reg && !dn_ready, v2_reg && $stable(x2_reg) && $stable(y2_reg), "gain stage 2 changed under stall")

endmodule

`default_nettype wire

// File: rtl/crvh_iter.sv
// One CORDIC micro-rotation stage for circular rotation, vectoring and hyperbolic modes.
// Depends on crvh_pkg for the angle tables and the hyperbolic shift sequence.
`default_nettype none

module crvh_iter #(
    parameter int STEP       = 0,
    parameter int DATA_WIDTH = crvh_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [1:0]                  up_func,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_x,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_y,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_z,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [1:0]                  dn_func,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_x,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_y,
    output logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] dn_z
);

`include "cordic_rotate_vector_hyperbolic_defines.svh"

    localparam int     W      = DATA_WIDTH + crvh_pkg::GUARD + crvh_pkg::HEADROOM;
    localparam int     CSHIFT = STEP;
    localparam int     HSHIFT = crvh_pkg::HYP_SHIFT[STEP];
    localparam longint CANG   = crvh_pkg::angle_const(crvh_pkg::CIRC_Q30[STEP], DATA_WIDTH);
    localparam longint HANG   = crvh_pkg::angle_const(crvh_pkg::HYP_Q30[HSHIFT-1], DATA_WIDTH);
    localparam logic signed [W-1:0] C_ANGLE = W'(CANG);
    localparam logic signed [W-1:0] H_ANGLE = W'(HANG);

    logic                valid_reg;
    logic [1:0]          func_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic signed [W-1:0] z_reg;
    logic signed [W-1:0] x_next;
    logic signed [W-1:0] y_next;
    logic signed [W-1:0] z_next;
    logic                hyp;
    logic                vec;
    logic                pos;
    logic                x_add;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] ang;

    // Direction: vectoring drives y to zero, rotation drives z to zero
    assign hyp   = (up_func == crvh_pkg::FUNC_HYP);
    assign vec   = (up_func == crvh_pkg::FUNC_VECTOR);
    assign pos   = vec ? up_y[W-1] : !up_z[W-1];
    assign x_add = hyp ? pos : !pos;

    // Shifted cross terms and step angle
    assign dx  = hyp ? (up_y >>> HSHIFT) : (up_y >>> CSHIFT);
    assign dy  = hyp ? (up_x >>> HSHIFT) : (up_x >>> CSHIFT);
    assign ang = hyp ? H_ANGLE : C_ANGLE;

    assign x_next = x_add ? (up_x + dx) : (up_x - dx);
    assign y_next = pos ? (up_y + dy) : (up_y - dy);
    assign z_next = pos ? (up_z - ang) : (up_z + ang);

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            func_reg <= up_func;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_func  = func_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;

    // Stage contents freeze while the next stage is full and stalled
    `CRVH_ASSERT_NEXT(a_iter_hold, valid_reg && !dn_ready, valid_reg && $stable(x_reg) && $stable(z_reg), "micro-rotation stage changed under stall")

endmodule

`default_nettype wire

// File: rtl/crvh_out.sv
// Output stage: rounds guard bits away, saturates to the field range, selects per mode.
// Depends on crvh_pkg; holds the output register of the block.
`default_nettype none

module crvh_out #(
    parameter int DATA_WIDTH = crvh_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [1:0]                  up_func,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_x,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_y,
    input  logic signed [DATA_WIDTH+crvh_pkg::GUARD+crvh_pkg::HEADROOM-1:0] up_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_y,
    output logic signed [DATA_WIDTH-1:0] out_angle
);

`include "cordic_rotate_vector_hyperbolic_defines.svh"

    localparam int G  = crvh_pkg::GUARD;
    localparam int W  = DATA_WIDTH + G + crvh_pkg::HEADROOM;
    localparam int R  = W - G + 1;
    localparam logic signed [W:0] FIN_ROUND = (W+1)'(1 << (G - 1));
    localparam logic signed [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Round half up out of the guard bits, then clamp
    function automatic logic signed [DATA_WIDTH-1:0] finish(input logic signed [W-1:0] v);
        logic signed [W:0]   biased;
        logic signed [W:0]   shifted;
        logic signed [R-1:0] r;
        logic                ovf;
        biased  = (W+1)'(v) + FIN_ROUND;
        shifted = biased >>> G;
        r       = shifted[R-1:0];
        ovf     = (r[R-1:DATA_WIDTH-1] != '0) && (r[R-1:DATA_WIDTH-1] != '1);
        if (ovf)
        begin
            return r[R-1] ? SAT_LO : SAT_HI;
        end
        return r[DATA_WIDTH-1:0];
    endfunction

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;
    logic signed [DATA_WIDTH-1:0] angle_reg;
    logic signed [DATA_WIDTH-1:0] x_next;
    logic signed [DATA_WIDTH-1:0] y_next;
    logic signed [DATA_WIDTH-1:0] angle_next;
    logic                         vec;

    // Vectoring reports magnitude and angle; the other modes report x and y
    assign vec        = (up_func == crvh_pkg::FUNC_VECTOR);
    assign x_next     = finish(up_x);
    assign y_next     = vec ? '0 : finish(up_y);
    assign angle_next = vec ? finish(up_z) : '0;

    assign up_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_angle = angle_reg;

    // No mode reports both a y component and an angle
    `CRVH_ASSERT_NOW(a_out_mode_fields, valid_reg, (y_reg == '0) || (angle_reg == '0), "output carries both y and angle")

endmodule

`default_nettype wire

// File: rtl/cordic_rotate_vector_hyperbolic.sv
// CORDIC rotate / vector / hyperbolic unit, fully pipelined.
// Stages: two gain-compensation stages, one stage per micro-rotation,
// two gain stages for the vectoring magnitude, output register.
// Throughput: one beat per cycle; a stall back-pressures stage by stage and fills bubbles.
// Reset (rst_n, async, active low) clears every stage valid bit; data registers are not reset.
`default_nettype none

module cordic_rotate_vector_hyperbolic #(
    parameter int ITERATIONS = crvh_pkg::ITERATIONS_DEF,
    parameter int DATA_WIDTH = crvh_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] in_x,
    input  logic signed [DATA_WIDTH-1:0] in_y,
    input  logic signed [DATA_WIDTH-1:0] in_angle,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_y,
    output logic signed [DATA_WIDTH-1:0] out_angle
);

    localparam int W = DATA_WIDTH + crvh_pkg::GUARD + crvh_pkg::HEADROOM;

    logic                pre_ready;
    crvh_pkg::gain_sel_t pre_sel;
    crvh_pkg::gain_sel_t post_sel;
    logic signed [W-1:0] x_ext;
    logic signed [W-1:0] y_ext;
    logic signed [W-1:0] z_ext;

    // Stage links: index k feeds micro-rotation k
    logic                s_valid [ITERATIONS+1];
    logic                s_ready [ITERATIONS+1];
    logic [1:0]          s_func  [ITERATIONS+1];
    logic signed [W-1:0] s_x     [ITERATIONS+1];
    logic signed [W-1:0] s_y     [ITERATIONS+1];
    logic signed [W-1:0] s_z     [ITERATIONS+1];

    logic                post_valid;
    logic                post_ready;
    logic [1:0]          post_func;
    logic signed [W-1:0] post_x;
    logic signed [W-1:0] post_y;
    logic signed [W-1:0] post_z;

    // Widen into the datapath format; vectoring starts its angle sum at zero
    assign x_ext = W'(in_x) <<< crvh_pkg::GUARD;
    assign y_ext = W'(in_y) <<< crvh_pkg::GUARD;
    assign z_ext = (func == crvh_pkg::FUNC_VECTOR) ? '0 : (W'(in_angle) <<< crvh_pkg::GUARD);

    assign pre_sel = '{
        scale_x: (func == crvh_pkg::FUNC_ROT_COMP),
        scale_y: (func == crvh_pkg::FUNC_ROT_COMP)
    };
    assign in_stall = !pre_ready;

    // Input gain compensation for compensated rotation
    crvh_gain #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pre_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (pre_ready),
        .up_sel   (pre_sel),
        .up_func  (func),
        .up_x     (x_ext),
        .up_y     (y_ext),
        .up_z     (z_ext),
        .dn_valid (s_valid[0]),
        .dn_ready (s_ready[0]),
        .dn_func  (s_func[0]),
        .dn_x     (s_x[0]),
        .dn_y     (s_y[0]),
        .dn_z     (s_z[0])
    );

    // Micro-rotation chain
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_iter
        crvh_iter #(
            .STEP       (k),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_iter (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (s_valid[k]),
            .up_ready (s_ready[k]),
            .up_func  (s_func[k]),
            .up_x     (s_x[k]),
            .up_y     (s_y[k]),
            .up_z     (s_z[k]),
            .dn_valid (s_valid[k+1]),
            .dn_ready (s_ready[k+1]),
            .dn_func  (s_func[k+1]),
            .dn_x     (s_x[k+1]),
            .dn_y     (s_y[k+1]),
            .dn_z     (s_z[k+1])
        );
    end

    // Output gain compensation for the vectoring magnitude
    assign post_sel = '{
        scale_x: (s_func[ITERATIONS] == crvh_pkg::FUNC_VECTOR),
        scale_y: 1'b0
    };

    crvh_gain #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_valid[ITERATIONS]),
        .up_ready (s_ready[ITERATIONS]),
        .up_sel   (post_sel),
        .up_func  (s_func[ITERATIONS]),
        .up_x     (s_x[ITERATIONS]),
        .up_y     (s_y[ITERATIONS]),
        .up_z     (s_z[ITERATIONS]),
        .dn_valid (post_valid),
        .dn_ready (post_ready),
        .dn_func  (post_func),
        .dn_x     (post_x),
        .dn_y     (post_y),
        .dn_z     (post_z)
    );

    // Round, saturate and register the result beat
    crvh_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (post_valid),
        .up_ready  (post_ready),
        .up_func   (post_func),
        .up_x      (post_x),
        .up_y      (post_y),
        .up_z      (post_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_angle (out_angle)
    );

endmodule

`default_nettype wire
